// File: hw/rtl/fbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Ring capacity. It must be a power of two, so that the ring indexes wrap
  // by plain truncation.
  localparam int MAX_BLOCKS = 64;
  localparam int ADDR_W     = 32;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int SIZE_W     = 16;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 4;

  localparam logic [SIZE_W-1:0] MIN_BLOCK_SIZE = SIZE_W'(4);

  // Configuration register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [ADDR_W-1:0] release_addr;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] block_addr;
    logic [CNT_W-1:0]  free_count;
  } rsp_t;

endpackage

// File: hw/rtl/fbpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Free list of equal-size block addresses kept as a ring in a RAM.
// ----------------------------------------------------------------------------
// One item is handled at a time and each item gives one result. A release, a
// failed allocate and an unused opcode finish in the cycle they are taken, so
// the next item can follow unless the result must wait in res. A successful
// allocate reads the free-list RAM, whose read port is registered, and
// finishes in S_READ. An init item writes the block addresses (at most 64)
// in S_INIT; the RAM write port stores one address per cycle. The free-list
// RAM has no reset and no clearing pass; only entries between head and tail
// are read. The result sits in an output register, so the next item is taken
// while an earlier result still waits on rsp_stall.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_INIT,
    S_PUSH
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] pool_base;
  logic [SIZE_W-1:0] block_size;
  logic [CNT_W-1:0]  block_count;

  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [CNT_W-1:0]  free_blocks;

  logic [IDX_W-1:0]  init_idx;
  logic [IDX_W-1:0]  init_last;
  logic [ADDR_W-1:0] init_addr;

  rsp_t              res;
  rsp_t              fin;
  logic              fin_valid;

  logic              req_fire;
  logic              rsp_free;
  logic              cfg_write;
  logic [CNT_W-1:0]  init_n;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign init_n    = (block_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : block_count;

  always_comb begin
    case (paddr[3:2])
      REG_POOL_BASE:   prdata = DATA_W'(pool_base);
      REG_BLOCK_SIZE:  prdata = DATA_W'(block_size);
      REG_BLOCK_COUNT: prdata = DATA_W'(block_count);
      default:         prdata = '0;
    endcase
  end

  fbpa_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_BLOCKS)
  ) u_free_list (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (head),
    .rd_data (ram_rdata)
  );

  // Result of the current step and the RAM accesses it makes.
  always_comb begin
    fin_valid      = 1'b0;
    fin            = res;
    ram_we         = 1'b0;
    ram_waddr      = tail;
    ram_wdata      = req.release_addr;
    ram_re         = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          fin.status     = ST_OK;
          fin.block_addr = '0;
          fin.free_count = free_blocks;
          case (req.opcode)
            OP_INIT: begin
              // A block too small for a pointer leaves everything as it was.
              if (block_size < MIN_BLOCK_SIZE) begin
                fin_valid = 1'b1;
              end else if (init_n == '0) begin
                fin_valid      = 1'b1;
                fin.free_count = '0;
              end
            end
            OP_ALLOC: begin
              if (free_blocks == '0) begin
                fin_valid  = 1'b1;
                fin.status = ST_EMPTY;
              end else begin
                ram_re = 1'b1;
              end
            end
            OP_RELEASE: begin
              fin_valid = 1'b1;
              if (free_blocks >= CNT_W'(MAX_BLOCKS)) begin
                fin.status = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                fin.free_count = free_blocks + CNT_W'(1);
              end
            end
            default: begin
              fin_valid = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        fin_valid      = 1'b1;
        fin.status     = ST_OK;
        fin.block_addr = ram_rdata;
        fin.free_count = free_blocks;
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_idx;
        ram_wdata = init_addr;
        if (init_idx == init_last) begin
          fin_valid      = 1'b1;
          fin.status     = ST_OK;
          fin.block_addr = '0;
          fin.free_count = CNT_W'(init_last) + CNT_W'(1);
        end
      end
      S_PUSH: begin
        fin_valid = 1'b1;
      end
      default: begin
        fin_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pool_base   <= '0;
      block_size  <= SIZE_W'(64);
      block_count <= CNT_W'(64);
      head        <= '0;
      tail        <= '0;
      free_blocks <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[3:2])
          REG_POOL_BASE:   pool_base   <= pwdata[ADDR_W-1:0];
          REG_BLOCK_SIZE:  block_size  <= pwdata[SIZE_W-1:0];
          REG_BLOCK_COUNT: block_count <= pwdata[CNT_W-1:0];
          default:         ;
        endcase
      end

      // Commit the free-list bookkeeping.
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            case (req.opcode)
              OP_INIT: begin
                if (block_size >= MIN_BLOCK_SIZE) begin
                  if (init_n == '0) begin
                    head        <= '0;
                    tail        <= '0;
                    free_blocks <= '0;
                  end else begin
                    state     <= S_INIT;
                    init_idx  <= '0;
                    init_last <= IDX_W'(init_n - CNT_W'(1));
                    init_addr <= pool_base;
                  end
                end
              end
              OP_ALLOC: begin
                if (free_blocks != '0) begin
                  state       <= S_READ;
                  head        <= head + IDX_W'(1);
                  free_blocks <= free_blocks - CNT_W'(1);
                end
              end
              OP_RELEASE: begin
                if (free_blocks < CNT_W'(MAX_BLOCKS)) begin
                  tail        <= tail + IDX_W'(1);
                  free_blocks <= free_blocks + CNT_W'(1);
                end
              end
              default: ;
            endcase
          end
        end
        S_INIT: begin
          init_idx  <= init_idx + IDX_W'(1);
          init_addr <= init_addr + ADDR_W'(block_size);
          if (init_idx == init_last) begin
            head        <= '0;
            tail        <= init_last + IDX_W'(1);
            free_blocks <= CNT_W'(init_last) + CNT_W'(1);
          end
        end
        default: ;
      endcase

      // A finished result goes to the output register, or waits in res.
      if (fin_valid) begin
        if (rsp_free) begin
          rsp_valid <= 1'b1;
          rsp       <= fin;
          state     <= S_IDLE;
        end else begin
          res   <= fin;
          state <= S_PUSH;
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    free_blocks <= CNT_W'(MAX_BLOCKS))
    else $error("free block count exceeds ring capacity");

  a_ring_consistent : assert property (@(posedge clk) disable iff (rst)
    (head + IDX_W'(free_blocks)) == tail)
    else $error("head, tail and free count disagree");

  a_full_count : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.free_count == CNT_W'(MAX_BLOCKS))
    else $error("full status with ring not full");

  a_empty_count : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EMPTY |-> rsp.free_count == '0 && rsp.block_addr == '0)
    else $error("empty status with free blocks left");

  a_read_follows_alloc : assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> $past(req_fire) && $past(req.opcode) == OP_ALLOC)
    else $error("read state entered without an allocate item");
`endif

endmodule

// File: verif/pool_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_checker
// Watches the request, response and register ports of the block pool
// allocator. It keeps its own copy of the free-list ring and the pool
// settings, predicts the response to every accepted request, and compares
// each accepted response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pool_checker
  import fbpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  req_t               req,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output int                 fail_count,
  output int                 outstanding
);

  logic [ADDR_W-1:0] ring [MAX_BLOCKS];
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [CNT_W-1:0]  free_n;
  logic [ADDR_W-1:0] base_q;
  logic [SIZE_W-1:0] size_q;
  logic [CNT_W-1:0]  count_q;
  rsp_t              due_rsp [$];
  int                errors = 0;

  task automatic apply_pool_op(input req_t r, output rsp_t res);
    logic [ADDR_W-1:0] addr;
    int                n;
    res.status     = ST_OK;
    res.block_addr = '0;
    case (r.opcode)
      OP_INIT: begin
        // A block too small to hold an address leaves the ring untouched.
        if (size_q >= MIN_BLOCK_SIZE) begin
          n    = (count_q > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_q);
          addr = base_q;
          for (int i = 0; i < n; i++) begin
            ring[i] = addr;
            addr    = addr + ADDR_W'(size_q);
          end
          head   = '0;
          // A full ring wraps the tail back to zero by truncation.
          tail   = IDX_W'(n);
          free_n = CNT_W'(n);
        end
      end
      OP_ALLOC: begin
        if (free_n == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.block_addr = ring[head];
          head           = head + 1'b1;
          free_n         = free_n - 1'b1;
        end
      end
      OP_RELEASE: begin
        if (free_n >= MAX_BLOCKS) begin
          res.status = ST_FULL;
        end else begin
          ring[tail] = r.release_addr;
          tail       = tail + 1'b1;
          free_n     = free_n + 1'b1;
        end
      end
      default: ;
    endcase
    res.free_count = free_n;
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      base_q  = '0;
      size_q  = SIZE_W'(64);
      count_q = CNT_W'(64);
      head    = '0;
      tail    = '0;
      free_n  = '0;
      due_rsp.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_POOL_BASE:   base_q  = pwdata[ADDR_W-1:0];
          REG_BLOCK_SIZE:  size_q  = pwdata[SIZE_W-1:0];
          REG_BLOCK_COUNT: count_q = pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
      // The output is registered, so a response taken at this edge always
      // belongs to an item accepted at an earlier edge.
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: response with no item pending: status %0d addr %h free %0d",
                     $realtime, rsp.status, rsp.block_addr, rsp.free_count);
        end else begin
          want = due_rsp.pop_front();
          if (rsp.status !== want.status || rsp.block_addr !== want.block_addr ||
              rsp.free_count !== want.free_count) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected status %0d addr %h free %0d, got status %0d addr %h free %0d",
                       $realtime, want.status, want.block_addr, want.free_count,
                       rsp.status, rsp.block_addr, rsp.free_count);
          end
        end
      end
      if (req_valid && !req_stall) begin
        apply_pool_op(req, want);
        due_rsp.push_back(want);
      end
    end
    fail_count  <= errors;
    outstanding <= due_rsp.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the block pool allocator with a directed opening and then random
// phases, each under fresh pool settings written over the register port.
// Requests and responses see random gaps and stalls; pool_checker predicts
// and compares every response, and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import fbpa_pkg::*;

  // The opcode encoding left unused by the block.
  localparam opcode_t OP_UNUSED = opcode_t'(2'd3);

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  req_t               req       = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  rsp_t               rsp;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0]  pwdata    = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  int                 fail_count;
  int                 outstanding;
  bit                 calm       = 1'b1;
  int                 stall_hold = 0;
  logic [ADDR_W-1:0]  cur_base   = '0;
  logic [SIZE_W-1:0]  cur_size   = SIZE_W'(64);

  always #5 clk = ~clk;

  fixed_block_pool_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  pool_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Mostly short idle spans, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (calm) begin
      rsp_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 65) begin
      rsp_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 6);
    end else begin
      rsp_stall  <= 1'b1;
      stall_hold <= gap_len() - 1;
    end
  end

  task automatic send(input opcode_t op, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 50) ? 0 : gap_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{opcode: op, release_addr: addr};
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // The pending count is registered in pool_checker, so look only from the next edge on.
  task automatic wait_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Bits above a register's width are sometimes filled with noise; the block drops them.
  task automatic configure(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                           input logic [CNT_W-1:0] count);
    logic [DATA_W-1:0] junk;
    junk = $urandom_range(0, 1) ? $urandom() : '0;
    write_reg(REG_POOL_BASE, base);
    write_reg(REG_BLOCK_SIZE, {junk[DATA_W-1:SIZE_W], size});
    write_reg(REG_BLOCK_COUNT, {junk[DATA_W-1:CNT_W], count});
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    cur_base = base;
    cur_size = size;
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  count;
    int                r;
    int                alloc_pct;
    int                waited;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset leaves the ring empty with the default pool settings.
    send(OP_ALLOC, '0);
    send(OP_UNUSED, 32'hFFFF_FFFF);
    send(OP_RELEASE, 32'hFFFF_FFFF);
    send(OP_RELEASE, 32'h0000_0000);
    send(OP_ALLOC, 32'hFFFF_FFFF);
    send(OP_ALLOC, '0);
    send(OP_ALLOC, '0);
    send(OP_INIT, 32'h5A5A_A5A5);
    send(OP_RELEASE, 32'h1234_5678);
    send(OP_ALLOC, '0);
    send(OP_RELEASE, 32'hDEAD_BEEF);
    req_valid <= 1'b0;
    calm      <= 1'b0;

    // Too many blocks, each as large as possible, running past the top of
    // the address space.
    wait_idle();
    configure(32'hFFFF_FF00, 16'hFFFF, 7'd127);
    send(OP_INIT, '0);
    send(OP_ALLOC, '0);
    send(OP_ALLOC, '0);
    send(OP_ALLOC, '0);
    req_valid <= 1'b0;

    // A block too small to hold an address: init leaves everything alone.
    wait_idle();
    configure(32'h0000_1000, 16'd3, 7'd8);
    send(OP_INIT, '0);
    send(OP_ALLOC, '0);
    req_valid <= 1'b0;

    wait_idle();
    configure(32'h8000_0000, 16'd4, 7'd0);
    send(OP_INIT, '0);
    send(OP_ALLOC, '0);
    req_valid <= 1'b0;

    wait_idle();
    configure(32'h0000_0000, 16'd4, 7'd1);
    send(OP_INIT, '0);
    send(OP_ALLOC, '0);
    send(OP_ALLOC, '0);
    send(OP_RELEASE, $urandom());
    req_valid <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      r    = $urandom_range(0, 99);
      base = (r < 20) ? '0 : (r < 40) ? '1 : ADDR_W'($urandom());
      r    = $urandom_range(0, 99);
      if (r < 15)      size = SIZE_W'(4);
      else if (r < 30) size = '1;
      else if (r < 38) size = SIZE_W'($urandom_range(0, 3));
      else if (r < 70) size = SIZE_W'($urandom_range(4, 64));
      else             size = SIZE_W'($urandom_range(65, 65535));
      r    = $urandom_range(0, 99);
      if (r < 20)      count = CNT_W'(64);
      else if (r < 35) count = CNT_W'(1);
      else if (r < 42) count = '0;
      else if (r < 50) count = CNT_W'($urandom_range(65, 127));
      else             count = CNT_W'($urandom_range(2, 63));
      wait_idle();
      configure(base, size, count);
      calm      <= (p == 3);
      alloc_pct = $urandom_range(25, 75);
      send(OP_INIT, $urandom());
      for (int k = 0; k < 74; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3)
          send(OP_INIT, $urandom());
        else if (r < 5)
          send(OP_UNUSED, $urandom());
        else if (r < 5 + alloc_pct * 95 / 100)
          send(OP_ALLOC, $urandom());
        else if ($urandom_range(0, 1))
          send(OP_RELEASE, $urandom());
        else
          send(OP_RELEASE, cur_base + ADDR_W'($urandom_range(0, 64) * cur_size));
      end
      req_valid <= 1'b0;
    end

    waited = 0;
    @(posedge clk);
    while (outstanding != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fixed_block_pool_allocator.sv
verif/pool_checker.sv
verif/testbench.sv
